FILE: hdl/skt_pkg.sv
// Shared constants, codes and control types for the sorted key table.
package skt_pkg;

  localparam int CAPACITY  = 16;
  localparam int KEY_WIDTH = 16;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int KEY_W     = 16;
  localparam int STATUS_W  = 2;
  localparam int POS_W     = 4;
  localparam int ENTRIES_W = 5;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;    // capture the accepted item and open the search window
    logic step;    // one binary search probe
    logic finish;  // update the table and write the result register
  } skt_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic search_done;  // search window is empty
    logic out_busy;     // result register holds an item that is not taken this cycle
  } skt_stat_t;

endpackage

FILE: hdl/skt_if.sv
// Valid/ready channel interfaces for request and result items.
interface skt_in_if;
  import skt_pkg::*;
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [KEY_W-1:0] key;
  modport source (output valid, output cmd, output key, input ready);
  modport sink   (input valid, input cmd, input key, output ready);
endinterface

interface skt_out_if;
  import skt_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [POS_W-1:0]     position;
  logic [ENTRIES_W-1:0] entries;
  modport source (output valid, output status, output position, output entries,
                  input ready);
  modport sink   (input valid, input status, input position, input entries,
                  output ready);
endinterface

FILE: hdl/skt_ctrl.sv
// Controller state machine sequencing load, search and finish.
module skt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  skt_pkg::skt_stat_t stat,
  output skt_pkg::skt_cmd_t  cmd
);
  import skt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } state_t;

  state_t state;

  // Hold state and advance on item acceptance, search completion and a free result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (req_valid) state <= ST_SEARCH;
        end
        ST_SEARCH: begin
          if (stat.search_done) state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!stat.out_busy) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Decode commands from the current state
  always_comb begin
    req_ready  = (state == ST_IDLE);
    cmd.load   = (state == ST_IDLE) && req_valid;
    cmd.step   = (state == ST_SEARCH) && !stat.search_done;
    cmd.finish = (state == ST_FINISH) && !stat.out_busy;
  end

endmodule

FILE: hdl/skt_dp.sv
// Datapath: key store, entry count, search window and result register.
module skt_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_cmd,
  input  logic [skt_pkg::KEY_W-1:0]     in_key,
  input  skt_pkg::skt_cmd_t             cmd,
  output skt_pkg::skt_stat_t            stat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [skt_pkg::STATUS_W-1:0]  out_status,
  output logic [skt_pkg::POS_W-1:0]     out_position,
  output logic [skt_pkg::ENTRIES_W-1:0] out_entries
);
  import skt_pkg::*;

  logic [KEY_WIDTH-1:0] key_store [CAPACITY];
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     lo;
  logic [CNT_W-1:0]     hi;
  logic                 cur_cmd;
  logic [KEY_WIDTH-1:0] cur_key;

  logic [CNT_W-1:0]     mid;
  logic [IDX_W-1:0]     rd_addr;
  logic [KEY_WIDTH-1:0] rd_data;
  logic                 go_right;
  logic                 is_insert;
  logic                 full;
  logic                 found;
  logic                 do_insert;

  // Probe address: midpoint while searching, bound when finishing
  always_comb begin
    mid       = lo + ((hi - lo) >> 1);
    rd_addr   = cmd.finish ? lo[IDX_W-1:0] : mid[IDX_W-1:0];
    rd_data   = key_store[rd_addr];
    is_insert = (cur_cmd == CMD_INSERT);
    go_right  = is_insert ? (rd_data <= cur_key) : (rd_data < cur_key);
    full      = (count == CNT_W'(CAPACITY));
    found     = (lo < count) && (rd_data == cur_key);
    do_insert = cmd.finish && is_insert && !full;
    stat.search_done = (lo >= hi);
    stat.out_busy    = out_valid && !out_ready;
  end

  // Capture the item and narrow the search window
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_cmd <= in_cmd;
      cur_key <= in_key[KEY_WIDTH-1:0];
      lo      <= '0;
      hi      <= count;
    end else if (cmd.step) begin
      if (go_right) lo <= mid + CNT_W'(1);
      else          hi <= mid;
    end
  end

  // Shift entries above the insert point up by one and drop in the key
  always_ff @(posedge clk) begin
    if (do_insert && (lo == '0)) key_store[0] <= cur_key;
  end

  for (genvar i = 1; i < CAPACITY; i++) begin : g_shift
    always_ff @(posedge clk) begin
      if (do_insert) begin
        if (CNT_W'(i) == lo) begin
          key_store[i] <= cur_key;
        end else if ((CNT_W'(i) > lo) && (CNT_W'(i) <= count)) begin
          key_store[i] <= key_store[i-1];
        end
      end
    end
  end

  // Hold entry count and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (do_insert) count <= count + CNT_W'(1);
      if (cmd.finish)     out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Write the result fields
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (is_insert) begin
        if (full) begin
          out_status   <= STATUS_FULL;
          out_position <= '0;
          out_entries  <= ENTRIES_W'(count);
        end else begin
          out_status   <= STATUS_OK;
          out_position <= lo[POS_W-1:0];
          out_entries  <= ENTRIES_W'(count + CNT_W'(1));
        end
      end else begin
        out_status   <= found ? STATUS_OK : STATUS_MISSING;
        out_position <= found ? lo[POS_W-1:0] : '0;
        out_entries  <= ENTRIES_W'(count);
      end
    end
  end

endmodule

FILE: hdl/sorted_key_table.sv
// Top level of the sorted key table: controller plus datapath.
//
// Holds up to 16 keys in ascending order. Each request item on req carries
// cmd (insert or lookup) and a 16-bit key. Each yields exactly one result
// item on rsp with status, position and the entry count after the item.
// Insert places the key after any equal keys; on a full table it is refused
// with status full. Lookup binary-searches and reports the lowest matching
// position, or status not found.
// The accepting edge loads the item, then the search probes the key store
// (up to 5 probes over 16 entries), the search state closes on an empty
// window, and the finish step updates the table and writes the result
// register to raise rsp.valid.
// One item is in work at a time. The next request is taken the cycle after
// the finish step, so a new item waits until the search over the key store
// and the finish step of the last one are done.
// The result register parts the two sides: a new request is taken while an
// earlier result waits. If rsp stays stalled, the next item waits in its
// finish step until the register frees.
// Reset (synchronous, rst high) empties the table and drops any result.
module sorted_key_table (
  input  logic      clk,
  input  logic      rst,
  skt_in_if.sink    req,
  skt_out_if.source rsp
);
  import skt_pkg::*;

  skt_cmd_t  cmd;
  skt_stat_t stat;

  // Sequence each item
  skt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Store, search and result
  skt_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .in_cmd       (req.cmd),
    .in_key       (req.key),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (rsp.valid),
    .out_ready    (rsp.ready),
    .out_status   (rsp.status),
    .out_position (rsp.position),
    .out_entries  (rsp.entries)
  );

endmodule

FILE: sim/sorted_key_table_checker.sv
// Result predictor and checker for the sorted key table.
module sorted_key_table_checker (
  input  logic clk,
  input  logic rst,
  skt_in_if    req,
  skt_out_if   rsp,
  output int   failures,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import skt_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [POS_W-1:0]     position;
    logic [ENTRIES_W-1:0] entries;
  } table_result_t;

  // Mirror of the table contents, ascending
  logic [KEY_W-1:0] mirror_keys [CAPACITY];
  int               mirror_count;
  table_result_t    results_due [$];

  initial begin
    failures = 0;
    pending = 0;
    mirror_count = 0;
  end

  // Apply one request to the mirror and return the result it should give
  function automatic table_result_t apply_request(input logic op,
                                                  input logic [KEY_W-1:0] key);
    table_result_t res;
    int lo;
    int hi;
    int mid;
    int i;
    res.status = STATUS_OK;
    res.position = '0;
    lo = 0;
    hi = mirror_count;
    if (op == CMD_INSERT) begin
      if (mirror_count >= CAPACITY) begin
        res.status = STATUS_FULL;
      end else begin
        // find the first key greater than the new one
        while (lo < hi) begin
          mid = (lo + hi) / 2;
          if (mirror_keys[mid] <= key) lo = mid + 1;
          else hi = mid;
        end
        for (i = mirror_count; i > lo; i--) mirror_keys[i] = mirror_keys[i-1];
        mirror_keys[lo] = key;
        mirror_count++;
        res.position = lo[POS_W-1:0];
      end
    end else begin
      // find the first key not below the wanted one
      while (lo < hi) begin
        mid = (lo + hi) / 2;
        if (mirror_keys[mid] < key) lo = mid + 1;
        else hi = mid;
      end
      if (lo < mirror_count && mirror_keys[lo] == key) res.position = lo[POS_W-1:0];
      else res.status = STATUS_MISSING;
    end
    res.entries = mirror_count[ENTRIES_W-1:0];
    return res;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    table_result_t want;
    if (rst) begin
      mirror_count = 0;
      results_due.delete();
    end else begin
      // compare a delivered result with the oldest prediction
      if (rsp.valid && rsp.ready) begin
        if (results_due.size() == 0) begin
          $error("result item with none expected: status %0d position %0d entries %0d",
                 rsp.status, rsp.position, rsp.entries);
          failures++;
        end else begin
          want = results_due.pop_front();
          check_field("status", 8'(want.status), 8'(rsp.status));
          check_field("position", 8'(want.position), 8'(rsp.position));
          check_field("entries", 8'(want.entries), 8'(rsp.entries));
        end
      end
      // predict each accepted request
      if (req.valid && req.ready) results_due.push_back(apply_request(req.cmd, req.key));
    end
    pending = results_due.size();
  end

endmodule

FILE: sim/sorted_key_table_test.sv
// Stimulus, clocking and verdict for the sorted key table.
module sorted_key_table_test;
  timeunit 1ns;
  timeprecision 1ps;
  import skt_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1530;
  localparam int CALM_TAIL    = 150;

  logic clk;
  logic rst;
  int   failures;
  int   pending;
  int   idle_pct;
  int   cycles;
  logic [KEY_W-1:0] stored_keys [$];

  skt_in_if  req_ch ();
  skt_out_if rsp_ch ();

  sorted_key_table u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  sorted_key_table_checker u_checker (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch),
    .rsp      (rsp_ch),
    .failures (failures),
    .pending  (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Present one request item, with an optional gap first; return once taken
  task automatic send_item(input logic op, input logic [KEY_W-1:0] key);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.cmd <= op;
    req_ch.key <= key;
    do @(posedge clk); while (!req_ch.ready);
    if (op == CMD_INSERT && stored_keys.size() < CAPACITY) stored_keys.push_back(key);
  endtask

  // Favor keys already held and their neighbors, then extremes and noise
  function automatic logic [KEY_W-1:0] pick_key();
    int sel;
    logic [KEY_W-1:0] k;
    sel = $urandom_range(0, 99);
    if (stored_keys.size() != 0 && sel < 55) begin
      k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
      if (sel >= 40) k = $urandom_range(0, 1) ? k + 1'b1 : k - 1'b1;
    end else if (sel < 65) begin
      case ($urandom_range(0, 3))
        0: k = '0;
        1: k = '1;
        2: k = 16'h1 << $urandom_range(0, 15);
        default: k = ~(16'h1 << $urandom_range(0, 15));
      endcase
    end else begin
      k = KEY_W'($urandom_range(0, 65535));
    end
    return k;
  endfunction

  // Result side: stall in random bursts while idling is on
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 4) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
    end
  end

  // Stop a hung run
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic op;
    bit   full;
    idle_pct = 0;
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.cmd <= CMD_INSERT;
    req_ch.key <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // lookups on the empty table
    send_item(CMD_LOOKUP, 16'h0000);
    send_item(CMD_LOOKUP, 16'hFFFF);
    // insert at front, middle and end, with duplicates
    send_item(CMD_INSERT, 16'h8000);
    send_item(CMD_INSERT, 16'h0000);
    send_item(CMD_INSERT, 16'hFFFF);
    send_item(CMD_INSERT, 16'h8000);
    send_item(CMD_INSERT, 16'h0000);
    // lowest match among duplicates, extremes, near misses
    send_item(CMD_LOOKUP, 16'h8000);
    send_item(CMD_LOOKUP, 16'h0000);
    send_item(CMD_LOOKUP, 16'hFFFF);
    send_item(CMD_LOOKUP, 16'h7FFF);
    send_item(CMD_LOOKUP, 16'h8001);
    send_item(CMD_INSERT, 16'h5555);
    send_item(CMD_INSERT, 16'hAAAA);
    send_item(CMD_INSERT, 16'h0001);
    send_item(CMD_LOOKUP, 16'hFFFE);
    send_item(CMD_LOOKUP, 16'h0001);

    // random items: fill the table, then mostly lookups and refused inserts
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 10;
          default: idle_pct = 40;
        endcase
      end
      if (n >= RANDOM_ITEMS - CALM_TAIL) idle_pct = 0;
      full = stored_keys.size() >= CAPACITY;
      op = ($urandom_range(0, 99) < (full ? 15 : 60)) ? CMD_INSERT : CMD_LOOKUP;
      send_item(op, pick_key());
    end
    req_ch.valid <= 1'b0;

    // drain outstanding results, then allow for stragglers
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
